// ----- hdl/size_class_block_pool_allocator_unit_assert.svh -----
// Assertion macros for the size-class block pool allocator.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef SIZE_CLASS_BLOCK_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define SIZE_CLASS_BLOCK_POOL_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTH

// Antecedent implies consequent in the same cycle.
`define SCBPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SCBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SCBPA_ASSERT_SAME(lbl, ante, cons, msg)
`define SCBPA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hdl/scbpa_pkg.sv -----
package scbpa_pkg;

  // Fixed field widths
  localparam int SIZE_W      = 16;
  localparam int CLASS_W     = 3;
  localparam int IDX_FIELD_W = 6;
  localparam int STATUS_W    = 3;

  // Limit registers on the configuration port
  localparam int NUM_LIMITS = 6;
  localparam int CFG_IDX_W  = 3;

  localparam logic [NUM_LIMITS-1:0][SIZE_W-1:0] LIMIT_RESET = {
    16'd1024, 16'd512, 16'd256, 16'd128, 16'd64, 16'd32
  };

  // Class code reported when no pool is involved
  localparam logic [CLASS_W-1:0] OUTSIDE_CLASS = 3'd6;

  // Request kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_OVERSIZE = 3'd2,
    ST_DOUBLE   = 3'd3,
    ST_OUTSIDE  = 3'd4
  } status_e;

  // Size routing result
  typedef struct packed {
    logic               hit;
    logic [CLASS_W-1:0] cls;
  } route_t;

endpackage

// ----- hdl/scbpa_link_ram.sv -----
module scbpa_link_ram
  import scbpa_pkg::*;
#(
  parameter int DEPTH = 384,
  parameter int WIDTH = 8
) (
  input  logic                                  clk_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/scbpa_class_route.sv -----
module scbpa_class_route
  import scbpa_pkg::*;
#(
  parameter int NUM_CLASSES = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i,
  input  logic [SIZE_W-1:0]    size_i,
  output route_t               route_o
);

  localparam int ROUTE_N = (NUM_CLASSES < NUM_LIMITS) ? NUM_CLASSES : NUM_LIMITS;

  logic [NUM_LIMITS-1:0][SIZE_W-1:0] limit_q;

  // Limit registers; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && ({1'b0, cfg_index_i} < (CFG_IDX_W+1)'(NUM_LIMITS))) begin
      limit_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // First class in order whose limit covers the size wins
  always_comb begin
    route_o = '{hit: 1'b0, cls: OUTSIDE_CLASS};
    for (int c = ROUTE_N - 1; c >= 0; c--) begin
      if (size_i <= limit_q[c]) begin
        route_o.hit = 1'b1;
        route_o.cls = CLASS_W'(c);
      end
    end
  end

endmodule

// ----- hdl/size_class_block_pool_allocator_unit.sv -----
// A result is registered when its request leaves S_EXEC, after the link memory
// read and only once the output register is free. No new request is taken until
// then: each pop or push reads the link memory before the pool head can change.
// Reset (async, active low): limits take their defaults, heads and fill counts
// clear; fresh blocks read as linked in index order, so no clearing pass runs.
module size_class_block_pool_allocator_unit
  import scbpa_pkg::*;
#(
  parameter int BLOCKS_PER_POOL = 64,
  parameter int NUM_CLASSES     = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [SIZE_W-1:0]      cfg_data_i,
  // Requests
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   action_i,
  input  logic [SIZE_W-1:0]      request_size_i,
  input  logic [CLASS_W-1:0]     free_class_i,
  input  logic [IDX_FIELD_W-1:0] free_index_i,
  // Results
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [CLASS_W-1:0]     block_class_o,
  output logic [IDX_FIELD_W-1:0] block_index_o
);

  `include "size_class_block_pool_allocator_unit_assert.svh"

  localparam int IDX_W  = $clog2(BLOCKS_PER_POOL + 1);
  localparam int BIDX_W = (BLOCKS_PER_POOL > 1) ? $clog2(BLOCKS_PER_POOL) : 1;
  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int DEPTH  = NUM_CLASSES * BLOCKS_PER_POOL;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W  = (IDX_W > IDX_FIELD_W) ? IDX_W : IDX_FIELD_W;
  localparam int MEM_W  = IDX_W + 1;

  localparam logic [IDX_W-1:0] EMPTY_MARK = IDX_W'(BLOCKS_PER_POOL);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;

  // Pool heads and per-pool fill counts (blocks at or above the count are fresh)
  logic [IDX_W-1:0] head_q [NUM_CLASSES];
  logic [IDX_W-1:0] hwm_q  [NUM_CLASSES];

  // Request held across the memory read
  logic              op_free_q;
  status_e           op_status_q;
  logic [CLS_W-1:0]  pool_q;
  logic [BIDX_W-1:0] slot_q;
  logic [ADDR_W-1:0] addr_q;
  logic              fresh_q;

  // Output register
  logic                   out_valid_q;
  logic [STATUS_W-1:0]    status_q;
  logic [CLASS_W-1:0]     block_class_q;
  logic [IDX_FIELD_W-1:0] block_index_q;

  route_t route;

  logic              in_xfer;
  logic              free_outside;
  status_e           acc_status;
  logic [CLS_W-1:0]  acc_pool;
  logic [BIDX_W-1:0] acc_slot;
  logic [ADDR_W-1:0] acc_addr;
  logic              acc_fresh;

  logic [MEM_W-1:0] mem_rdata;
  logic [MEM_W-1:0] mem_wdata;
  logic             mem_we;

  logic                   advance;
  logic                   eff_taken;
  logic [IDX_W-1:0]       eff_link;
  logic                   wr_hit;
  logic                   do_pop;
  logic                   do_push;
  status_e                res_status;
  logic [CLASS_W-1:0]     res_cls;
  logic [IDX_FIELD_W-1:0] res_idx;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;

  scbpa_class_route #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_route (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .size_i     (request_size_i),
    .route_o    (route)
  );

  // Decode the request and pick the block to read
  always_comb begin
    free_outside = ({1'b0, free_class_i} >= (CLASS_W+1)'(NUM_CLASSES)) ||
                   (CMP_W'(free_index_i) >= CMP_W'(BLOCKS_PER_POOL));
    acc_status = ST_OK;
    acc_pool   = '0;
    acc_slot   = '0;
    if (action_i == ACT_FREE) begin
      if (free_outside) begin
        acc_status = ST_OUTSIDE;
      end else begin
        acc_pool = CLS_W'(free_class_i);
        acc_slot = BIDX_W'(free_index_i);
      end
    end else begin
      if (!route.hit) begin
        acc_status = ST_OVERSIZE;
      end else begin
        acc_pool = CLS_W'(route.cls);
        if (head_q[acc_pool] == EMPTY_MARK) begin
          acc_status = ST_EMPTY;
        end else begin
          acc_slot = BIDX_W'(head_q[acc_pool]);
        end
      end
    end
    acc_addr  = ADDR_W'(acc_pool) * ADDR_W'(BLOCKS_PER_POOL) + ADDR_W'(acc_slot);
    acc_fresh = !(IDX_W'(acc_slot) < hwm_q[acc_pool]);
  end

  scbpa_link_ram #(
    .DEPTH(DEPTH),
    .WIDTH(MEM_W)
  ) u_ram (
    .clk_i  (clk_i),
    .re_i   (in_xfer),
    .raddr_i(acc_addr),
    .rdata_o(mem_rdata),
    .we_i   (mem_we),
    .waddr_i(addr_q),
    .wdata_i(mem_wdata)
  );

  // Finish the pop or push once the link entry is back
  always_comb begin
    advance    = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
    eff_taken  = fresh_q ? 1'b0 : mem_rdata[IDX_W];
    eff_link   = fresh_q ? (IDX_W'(slot_q) + IDX_W'(1)) : mem_rdata[IDX_W-1:0];
    wr_hit     = 1'b0;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    mem_wdata  = '0;
    res_status = op_status_q;
    res_cls    = OUTSIDE_CLASS;
    res_idx    = '0;
    if (op_status_q == ST_OK) begin
      res_cls = CLASS_W'(pool_q);
      res_idx = IDX_FIELD_W'(slot_q);
      if (op_free_q) begin
        if (!eff_taken) begin
          res_status = ST_DOUBLE;
        end else begin
          do_push   = 1'b1;
          wr_hit    = 1'b1;
          mem_wdata = {1'b0, head_q[pool_q]};
        end
      end else begin
        do_pop    = 1'b1;
        wr_hit    = 1'b1;
        mem_wdata = {1'b1, eff_link};
      end
    end
    mem_we = advance && wr_hit;
  end

  // Sequencer, pool state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_free_q     <= 1'b0;
      op_status_q   <= ST_OK;
      pool_q        <= '0;
      slot_q        <= '0;
      addr_q        <= '0;
      fresh_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      status_q      <= '0;
      block_class_q <= '0;
      block_index_q <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c] <= '0;
        hwm_q[c]  <= '0;
      end
    end else begin
      // Result leaves unless a new one replaces it in the same cycle
      if (out_valid_q && out_ready_i && !advance) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_free_q   <= (action_i == ACT_FREE);
            op_status_q <= acc_status;
            pool_q      <= acc_pool;
            slot_q      <= acc_slot;
            addr_q      <= acc_addr;
            fresh_q     <= acc_fresh;
            state_q     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (advance) begin
            out_valid_q   <= 1'b1;
            status_q      <= res_status;
            block_class_q <= res_cls;
            block_index_q <= res_idx;
            if (do_pop) begin
              head_q[pool_q] <= eff_link;
              if (fresh_q) begin
                hwm_q[pool_q] <= IDX_W'(slot_q) + IDX_W'(1);
              end
            end
            if (do_push) begin
              head_q[pool_q] <= IDX_W'(slot_q);
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign block_class_o = block_class_q;
  assign block_index_o = block_index_q;

  // Checks
  `SCBPA_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "request taken while busy")
  `SCBPA_ASSERT_NEXT(a_stall_holds, (state_q == S_EXEC) && out_valid_q && !out_ready_i, state_q == S_EXEC, "result dropped on stall")
  `SCBPA_ASSERT_NEXT(a_write_gives_ok, mem_we, out_valid_o && (status_o == ST_OK), "link write without ok result")
  `SCBPA_ASSERT_SAME(a_write_in_exec, mem_we, (state_q == S_EXEC) && (op_status_q == ST_OK), "stray link write")

endmodule
